### rtl/weighted_grid_neighbour_expand_unit_macros.svh
// assertion macros for the weighted grid neighbour expand unit
`ifndef WEIGHTED_GRID_NEIGHBOUR_EXPAND_UNIT_MACROS_SVH
`define WEIGHTED_GRID_NEIGHBOUR_EXPAND_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define WGNE_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define WGNE_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`else

`define WGNE_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg)
`define WGNE_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)

`endif

`endif

### rtl/wgne_pkg.sv
// shared types, constants and helpers of the weighted grid neighbour expand unit
package wgne_pkg;

    localparam int ID_BITS    = 24;
    localparam int COST_BITS  = 16;
    localparam int PITCH_BITS = 16;
    localparam int STEP_BITS  = 17;
    localparam int NUM_DIRS   = 8;

    // sqrt2/4 in unsigned q0.16
    localparam int K_BITS    = 15;
    localparam int K_SHIFT   = 16;
    localparam logic [K_BITS-1:0] DIAG_K = K_BITS'(23170);

    localparam int SUM_BITS  = COST_BITS + 2;
    localparam int PROD_BITS = SUM_BITS + K_BITS;

    localparam logic [STEP_BITS-1:0] COST_MAX   = {STEP_BITS{1'b1}};
    localparam logic [PITCH_BITS-1:0] PITCH_RST = PITCH_BITS'(258);

    // direction codes, also the emission order
    typedef enum logic [2:0] {
        DIR_N  = 3'd0,
        DIR_NE = 3'd1,
        DIR_NW = 3'd2,
        DIR_S  = 3'd3,
        DIR_SE = 3'd4,
        DIR_SW = 3'd5,
        DIR_E  = 3'd6,
        DIR_W  = 3'd7
    } t_dir;

    typedef struct packed {
        logic [ID_BITS-1:0]   node_id;
        logic [COST_BITS-1:0] cost_center;
        logic [COST_BITS-1:0] cost_north;
        logic [COST_BITS-1:0] cost_south;
        logic [COST_BITS-1:0] cost_east;
        logic [COST_BITS-1:0] cost_west;
        logic [COST_BITS-1:0] cost_northeast;
        logic [COST_BITS-1:0] cost_northwest;
        logic [COST_BITS-1:0] cost_southeast;
        logic [COST_BITS-1:0] cost_southwest;
    } t_in_item;

    typedef struct packed {
        logic                 found;
        logic [ID_BITS-1:0]   neighbour_id;
        logic [2:0]           direction;
        logic [STEP_BITS-1:0] step_cost;
        logic                 last;
    } t_out_item;

    // open-neighbour mask, bit index equals direction code
    function automatic logic [NUM_DIRS-1:0] open_mask(input t_in_item it);
        logic n, s, e, w;
        logic [NUM_DIRS-1:0] m;
        n = (it.cost_north != '0);
        s = (it.cost_south != '0);
        e = (it.cost_east != '0);
        w = (it.cost_west != '0);
        m = '0;
        m[DIR_N]  = n;
        m[DIR_NE] = n && e && (it.cost_northeast != '0);
        m[DIR_NW] = n && w && (it.cost_northwest != '0);
        m[DIR_S]  = s;
        m[DIR_SE] = s && e && (it.cost_southeast != '0);
        m[DIR_SW] = s && w && (it.cost_southwest != '0);
        m[DIR_E]  = e;
        m[DIR_W]  = w;
        return m;
    endfunction

endpackage

### rtl/wgne_select.sv
// picks the next pending neighbour of the held cell and forms its result
module wgne_select (
    input  wgne_pkg::t_in_item                 i_item,
    input  logic [wgne_pkg::NUM_DIRS-1:0]      i_pend,
    input  logic [wgne_pkg::ID_BITS-1:0]       i_id_north,
    input  logic [wgne_pkg::ID_BITS-1:0]       i_id_south,
    output wgne_pkg::t_out_item                o_result,
    output logic [wgne_pkg::NUM_DIRS-1:0]      o_pend_next
);
    import wgne_pkg::*;

    t_dir                  w_dir;
    logic                  w_any;
    logic                  w_diag;
    logic [ID_BITS-1:0]    w_base;
    logic [ID_BITS-1:0]    w_id;
    logic [COST_BITS-1:0]  w_a;
    logic [COST_BITS-1:0]  w_b;
    logic [COST_BITS-1:0]  w_d;
    logic [SUM_BITS-1:0]   w_sum;
    logic [PROD_BITS-1:0]  w_prod;
    logic [PROD_BITS-1:0]  w_raw;
    logic [STEP_BITS-1:0]  w_cost;

    // lowest pending bit is the next direction in emission order
    always_comb begin
        w_dir = DIR_N;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
            if (i_pend[i]) begin
                w_dir = t_dir'(i);
            end
        end
    end

    assign w_any       = (i_pend != '0);
    assign o_pend_next = i_pend & (i_pend - NUM_DIRS'(1));

    // operand and base id selection per direction
    always_comb begin
        w_base = i_item.node_id;
        w_a    = '0;
        w_b    = '0;
        w_d    = '0;
        w_diag = 1'b0;
        w_id   = i_item.node_id;
        unique case (w_dir)
            DIR_N: begin
                w_a  = i_item.cost_north;
                w_id = i_id_north;
            end
            DIR_NE: begin
                w_a    = i_item.cost_north;
                w_b    = i_item.cost_east;
                w_d    = i_item.cost_northeast;
                w_diag = 1'b1;
                w_base = i_id_north;
                w_id   = w_base + ID_BITS'(1);
            end
            DIR_NW: begin
                w_a    = i_item.cost_north;
                w_b    = i_item.cost_west;
                w_d    = i_item.cost_northwest;
                w_diag = 1'b1;
                w_base = i_id_north;
                w_id   = w_base - ID_BITS'(1);
            end
            DIR_S: begin
                w_a  = i_item.cost_south;
                w_id = i_id_south;
            end
            DIR_SE: begin
                w_a    = i_item.cost_south;
                w_b    = i_item.cost_east;
                w_d    = i_item.cost_southeast;
                w_diag = 1'b1;
                w_base = i_id_south;
                w_id   = w_base + ID_BITS'(1);
            end
            DIR_SW: begin
                w_a    = i_item.cost_south;
                w_b    = i_item.cost_west;
                w_d    = i_item.cost_southwest;
                w_diag = 1'b1;
                w_base = i_id_south;
                w_id   = w_base - ID_BITS'(1);
            end
            DIR_E: begin
                w_a  = i_item.cost_east;
                w_id = i_item.node_id + ID_BITS'(1);
            end
            DIR_W: begin
                w_a  = i_item.cost_west;
                w_id = i_item.node_id - ID_BITS'(1);
            end
            default: begin
                w_id = i_item.node_id;
            end
        endcase
    end

    // step cost: mean for orthogonal, scaled four-cell sum for diagonal
    assign w_sum  = SUM_BITS'(i_item.cost_center) + SUM_BITS'(w_a)
                  + SUM_BITS'(w_b) + SUM_BITS'(w_d);
    assign w_prod = PROD_BITS'(w_sum) * PROD_BITS'(DIAG_K);
    assign w_raw  = w_diag ? (w_prod >> K_SHIFT) : (PROD_BITS'(w_sum) >> 1);
    assign w_cost = (w_raw > PROD_BITS'(COST_MAX)) ? COST_MAX : w_raw[STEP_BITS-1:0];

    // result, or the empty marker when nothing is open
    always_comb begin
        o_result.found        = w_any;
        o_result.neighbour_id = w_any ? w_id : '0;
        o_result.direction    = w_any ? w_dir : DIR_N;
        o_result.step_cost    = w_any ? w_cost : '0;
        o_result.last         = (o_pend_next == '0);
    end

endmodule

### rtl/weighted_grid_neighbour_expand_unit.sv
// Weighted grid neighbour expand unit: takes a cell id with the nine q8.8 costs of its
// 3x3 neighbourhood (zero is blocked) and emits one result per open neighbour in the
// order N, NE, NW, S, SE, SW, E, W, with last set on the final one, or a single result
// with found clear when nothing is open. An accepted cell sits in the input register and
// one neighbour is produced into the output register per cycle unless the output stalls,
// so a cell with k open neighbours gives max(k,1) results (1 to 8); the next cell is
// accepted in the same cycle its last result is formed, so cells follow with no gap.
// The step cost for a neighbour uses one 18x15 multiply between the two registers.
// row_pitch may only be written while no cell is in flight.
`include "weighted_grid_neighbour_expand_unit_macros.svh"

module weighted_grid_neighbour_expand_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wgne_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output wgne_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wgne_pkg::PITCH_BITS-1:0]   i_cfg_data
);
    import wgne_pkg::*;

    logic                  r_in_valid,  n_in_valid;
    t_in_item              r_item,      n_item;
    logic [NUM_DIRS-1:0]   r_pend,      n_pend;
    logic [ID_BITS-1:0]    r_id_north,  n_id_north;
    logic [ID_BITS-1:0]    r_id_south,  n_id_south;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out,       n_out;
    logic [PITCH_BITS-1:0] r_pitch,     n_pitch;

    logic                  w_emit;
    logic                  w_done;
    logic                  w_accept;
    t_out_item             w_result;
    logic [NUM_DIRS-1:0]   w_pend_next;

    // neighbour selection and cost datapath
    wgne_select u_select (
        .i_item      (r_item),
        .i_pend      (r_pend),
        .i_id_north  (r_id_north),
        .i_id_south  (r_id_south),
        .o_result    (w_result),
        .o_pend_next (w_pend_next)
    );

    // handshake control
    assign w_emit      = r_in_valid && (!r_out_valid || i_out_ready);
    assign w_done      = w_emit && w_result.last;
    assign o_in_ready  = !r_in_valid || w_done;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // next state
    always_comb begin
        n_in_valid  = r_in_valid;
        n_item      = r_item;
        n_pend      = r_pend;
        n_id_north  = r_id_north;
        n_id_south  = r_id_south;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_pitch     = r_pitch;

        if (i_cfg_valid) begin
            n_pitch = i_cfg_data;
        end

        // input register: load on a transaction, else walk the pending mask
        if (w_accept) begin
            n_in_valid = 1'b1;
            n_item     = i_in_data;
            n_pend     = open_mask(i_in_data);
            n_id_north = i_in_data.node_id - ID_BITS'(r_pitch);
            n_id_south = i_in_data.node_id + ID_BITS'(r_pitch);
        end else if (w_done) begin
            n_in_valid = 1'b0;
            n_pend     = w_pend_next;
        end else if (w_emit) begin
            n_pend = w_pend_next;
        end

        // output register
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out       = w_result;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
            r_pitch     <= PITCH_RST;
        end else begin
            r_in_valid  <= n_in_valid;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_pitch     <= n_pitch;
        end
        r_item     <= n_item;
        r_id_north <= n_id_north;
        r_id_south <= n_id_south;
        r_out      <= n_out;
    end

    // checks
    `WGNE_ASSERT_IMPLY(a_empty_is_last, i_clk, i_rst_n, o_out_valid && !o_out_data.found, o_out_data.last, "empty result without last")
    `WGNE_ASSERT_IMPLY(a_empty_is_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.found, (o_out_data.neighbour_id == '0) && (o_out_data.step_cost == '0) && (o_out_data.direction == DIR_N), "empty result with nonzero fields")
    `WGNE_ASSERT_IMPLY(a_take_only_at_end, i_clk, i_rst_n, r_in_valid && o_in_ready, w_emit && w_result.last, "new cell taken before the held one finished")
    `WGNE_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, w_accept, r_in_valid, "accepted cell not held")

endmodule

### tb/tb_weighted_grid_neighbour_expand_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for the weighted grid neighbour expand unit

// expected neighbour list per expanded cell, checked in order of arrival
class cell_scoreboard;
    wgne_pkg::t_out_item           want_q[$];
    logic [wgne_pkg::PITCH_BITS-1:0] pitch;
    int                            errors;

    function new();
        pitch  = wgne_pkg::PITCH_RST;
        errors = 0;
    endfunction

    // one line per mismatch
    task report(input string msg);
        errors++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // mean of two q8.8 cells, truncated
    function logic [wgne_pkg::STEP_BITS-1:0] straight_cost(
        input logic [wgne_pkg::COST_BITS-1:0] a, input logic [wgne_pkg::COST_BITS-1:0] b);
        logic [wgne_pkg::COST_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return wgne_pkg::STEP_BITS'(sum >> 1);
    endfunction

    // four cells times sqrt2/4 in q0.16, truncated
    function logic [wgne_pkg::STEP_BITS-1:0] corner_cost(
        input logic [wgne_pkg::COST_BITS-1:0] a, input logic [wgne_pkg::COST_BITS-1:0] b,
        input logic [wgne_pkg::COST_BITS-1:0] c, input logic [wgne_pkg::COST_BITS-1:0] d);
        logic [17:0] sum;
        logic [33:0] prod;
        sum  = 18'(a) + 18'(b) + 18'(c) + 18'(d);
        prod = 34'(sum) * 34'(wgne_pkg::DIAG_K);
        if (prod[33:16] > 18'(wgne_pkg::COST_MAX))
            return wgne_pkg::COST_MAX;
        return prod[32:16];
    endfunction

    function wgne_pkg::t_out_item make_hop(input logic [wgne_pkg::ID_BITS-1:0] id,
                                           input wgne_pkg::t_dir dir,
                                           input logic [wgne_pkg::STEP_BITS-1:0] cost);
        wgne_pkg::t_out_item r;
        r = '0;
        r.found        = 1'b1;
        r.neighbour_id = id;
        r.direction    = dir;
        r.step_cost    = cost;
        return r;
    endfunction

    // work out the neighbour list of an accepted cell
    function void note_cell(input wgne_pkg::t_in_item nb);
        wgne_pkg::t_out_item hops[$];
        wgne_pkg::t_out_item none;
        logic [wgne_pkg::ID_BITS-1:0] up_id, dn_id;
        logic n_open, s_open, e_open, w_open;
        n_open = (nb.cost_north != 0);
        s_open = (nb.cost_south != 0);
        e_open = (nb.cost_east != 0);
        w_open = (nb.cost_west != 0);
        up_id  = nb.node_id - wgne_pkg::ID_BITS'(pitch);
        dn_id  = nb.node_id + wgne_pkg::ID_BITS'(pitch);
        if (n_open) begin
            hops.push_back(make_hop(up_id, wgne_pkg::DIR_N,
                                    straight_cost(nb.cost_center, nb.cost_north)));
            if (e_open && nb.cost_northeast != 0)
                hops.push_back(make_hop(up_id + wgne_pkg::ID_BITS'(1), wgne_pkg::DIR_NE,
                    corner_cost(nb.cost_center, nb.cost_north, nb.cost_east,
                                nb.cost_northeast)));
            if (w_open && nb.cost_northwest != 0)
                hops.push_back(make_hop(up_id - wgne_pkg::ID_BITS'(1), wgne_pkg::DIR_NW,
                    corner_cost(nb.cost_center, nb.cost_north, nb.cost_west,
                                nb.cost_northwest)));
        end
        if (s_open) begin
            hops.push_back(make_hop(dn_id, wgne_pkg::DIR_S,
                                    straight_cost(nb.cost_center, nb.cost_south)));
            if (e_open && nb.cost_southeast != 0)
                hops.push_back(make_hop(dn_id + wgne_pkg::ID_BITS'(1), wgne_pkg::DIR_SE,
                    corner_cost(nb.cost_center, nb.cost_south, nb.cost_east,
                                nb.cost_southeast)));
            if (w_open && nb.cost_southwest != 0)
                hops.push_back(make_hop(dn_id - wgne_pkg::ID_BITS'(1), wgne_pkg::DIR_SW,
                    corner_cost(nb.cost_center, nb.cost_south, nb.cost_west,
                                nb.cost_southwest)));
        end
        if (e_open)
            hops.push_back(make_hop(nb.node_id + wgne_pkg::ID_BITS'(1), wgne_pkg::DIR_E,
                                    straight_cost(nb.cost_center, nb.cost_east)));
        if (w_open)
            hops.push_back(make_hop(nb.node_id - wgne_pkg::ID_BITS'(1), wgne_pkg::DIR_W,
                                    straight_cost(nb.cost_center, nb.cost_west)));
        // boxed-in cell gives a single empty result
        if (hops.size() == 0) begin
            none      = '0;
            none.last = 1'b1;
            hops.push_back(none);
        end else begin
            hops[hops.size()-1].last = 1'b1;
        end
        foreach (hops[i])
            want_q.push_back(hops[i]);
    endfunction

    // compare one accepted result with the oldest expected one
    task check_result(input wgne_pkg::t_out_item got);
        wgne_pkg::t_out_item want;
        if (want_q.size() == 0) begin
            report($sformatf("result with nothing expected: %p", got));
            return;
        end
        want = want_q.pop_front();
        if (got.found !== want.found)
            report($sformatf("found %0b, expected %0b", got.found, want.found));
        if (got.neighbour_id !== want.neighbour_id)
            report($sformatf("neighbour_id %0h, expected %0h",
                             got.neighbour_id, want.neighbour_id));
        if (got.direction !== want.direction)
            report($sformatf("direction %0d, expected %0d", got.direction, want.direction));
        if (got.step_cost !== want.step_cost)
            report($sformatf("step_cost %0h, expected %0h (dir %0d)",
                             got.step_cost, want.step_cost, want.direction));
        if (got.last !== want.last)
            report($sformatf("last %0b, expected %0b (dir %0d)",
                             got.last, want.last, want.direction));
    endtask

    function int pending();
        return want_q.size();
    endfunction
endclass

module tb_weighted_grid_neighbour_expand_unit;
    import wgne_pkg::*;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [PITCH_BITS-1:0] i_cfg_data  = '0;

    cell_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit stall_req     = 1'b0;
    int stall_left    = 0;

    weighted_grid_neighbour_expand_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result side back-pressure, with one long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (stall_req) begin
                stall_left = 300;
                stall_req  = 1'b0;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // every accepted result transaction is checked
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
    end

    // offer one cell and hold it until the transaction completes
    task automatic push_cell(input t_in_item nb);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= nb;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_cell(nb);
    endtask

    // let the block run dry before touching the register
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_pitch(input logic [PITCH_BITS-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.pitch = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item mk(input logic [ID_BITS-1:0] id,
                                    input logic [15:0] c, input logic [15:0] n,
                                    input logic [15:0] s, input logic [15:0] e,
                                    input logic [15:0] w, input logic [15:0] ne,
                                    input logic [15:0] nw, input logic [15:0] se,
                                    input logic [15:0] sw);
        t_in_item nb;
        nb.node_id        = id;
        nb.cost_center    = c;
        nb.cost_north     = n;
        nb.cost_south     = s;
        nb.cost_east      = e;
        nb.cost_west      = w;
        nb.cost_northeast = ne;
        nb.cost_northwest = nw;
        nb.cost_southeast = se;
        nb.cost_southwest = sw;
        return nb;
    endfunction

    // blocked, tiny, full-scale or any cost
    function automatic logic [15:0] rand_cost();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 16'h0000;
        if (r < 40) return 16'($urandom_range(4, 1));
        if (r < 50) return 16'hFFFF;
        return 16'($urandom_range(65535, 1));
    endfunction

    function automatic t_in_item rand_cell();
        t_in_item nb;
        int r;
        r = $urandom_range(99);
        if (r < 10)
            nb.node_id = ID_BITS'($urandom_range(300));
        else if (r < 20)
            nb.node_id = {ID_BITS{1'b1}} - ID_BITS'($urandom_range(300));
        else
            nb.node_id = ID_BITS'($urandom);
        nb.cost_center    = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
        nb.cost_north     = rand_cost();
        nb.cost_south     = rand_cost();
        nb.cost_east      = rand_cost();
        nb.cost_west      = rand_cost();
        nb.cost_northeast = rand_cost();
        nb.cost_northwest = rand_cost();
        nb.cost_southeast = rand_cost();
        nb.cost_southwest = rand_cost();
        return nb;
    endfunction

    task automatic run_random(input int count);
        repeat (count) push_cell(rand_cell());
    endtask

    // edges of the fields, each orthogonal direction alone, and the corner rules
    task automatic run_directed();
        push_cell(mk(24'h001234, 16'h0100, 16'h0180, 16'h0200, 16'h0120, 16'h0140,
                     16'h0300, 16'h0280, 16'h0260, 16'h0220));
        push_cell(mk(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        push_cell(mk(24'h000000, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
                     16'h0001, 16'h0001, 16'h0001, 16'h0001));
        // boxed in, with and without a center cost
        push_cell(mk(24'h000010, 16'h0100, 0, 0, 0, 0, 16'h0100, 16'h0100, 16'h0100,
                     16'h0100));
        push_cell(mk(24'hFFFFFF, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0));
        // blocked center still walkable out of
        push_cell(mk(24'h000500, 16'h0000, 16'h0200, 16'h0200, 16'h0200, 16'h0200,
                     16'h0200, 16'h0200, 16'h0200, 16'h0200));
        // single orthogonal openings, corners present but not reachable
        push_cell(mk(24'h000400, 16'h0100, 16'h0101, 0, 0, 0, 16'h0100, 16'h0100,
                     16'h0100, 16'h0100));
        push_cell(mk(24'h000400, 16'h0100, 0, 16'h0103, 0, 0, 16'h0100, 16'h0100,
                     16'h0100, 16'h0100));
        push_cell(mk(24'h000400, 16'h0100, 0, 0, 16'h0105, 0, 16'h0100, 16'h0100,
                     16'h0100, 16'h0100));
        push_cell(mk(24'h000400, 16'h0100, 0, 0, 0, 16'h0107, 16'h0100, 16'h0100,
                     16'h0100, 16'h0100));
        // corner cut needs the side open as well
        push_cell(mk(24'h000800, 16'h0100, 16'h0100, 0, 0, 0, 16'h0100, 0, 0, 0));
        push_cell(mk(24'h000800, 16'h0100, 0, 0, 16'h0100, 0, 16'h0100, 0, 0, 0));
        push_cell(mk(24'h000800, 16'h0123, 16'h0456, 0, 16'h0789, 0, 16'h0ABC, 0, 0, 0));
        push_cell(mk(24'h000800, 16'h0123, 16'h0456, 0, 0, 16'h0789, 0, 16'h0ABC, 0, 0));
        push_cell(mk(24'h000800, 16'h0123, 0, 16'h0456, 16'h0789, 0, 0, 0, 16'h0ABC, 0));
        push_cell(mk(24'h000800, 16'h0123, 0, 16'h0456, 0, 16'h0789, 0, 0, 0, 16'h0ABC));
        // odd sums to exercise truncation
        push_cell(mk(24'h000001, 16'h0001, 16'hFFFF, 16'h0002, 16'hFFFE, 16'h0003,
                     16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF));
        push_cell(mk(24'hAAAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                     16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA));
        push_cell(mk(24'h555555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555,
                     16'h5555, 16'h5555, 16'h5555, 16'h5555));
        push_cell(mk(24'h000102, 16'h8000, 16'h0001, 16'h8000, 16'h7FFF, 16'h8001,
                     16'h0001, 16'hFFFF, 16'h8000, 16'h0002));
    endtask

    // stimulus and end of run
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset pitch, sender idles lightly, receiver heavily
        send_idle_pct = 29;
        recv_idle_pct = 62;
        run_directed();
        run_random(60);
        write_pitch(PITCH_BITS'(3));
        run_random(70);

        // roles swapped, widest pitch, one long result stall
        send_idle_pct = 62;
        recv_idle_pct = 29;
        write_pitch({PITCH_BITS{1'b1}});
        run_random(20);
        stall_req = 1'b1;
        run_random(100);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_pitch(PITCH_BITS'($urandom_range(65535, 3)));
        run_random(90);
        // pitch below a real grid row, neighbour ids may overlap
        write_pitch(PITCH_BITS'(1));
        run_random(20);

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** weighted_grid_neighbour_expand_unit: PASSED **");
        else
            $display("** weighted_grid_neighbour_expand_unit: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("** weighted_grid_neighbour_expand_unit: FAILED **");
        $finish;
    end
endmodule

### weighted_grid_neighbour_expand_unit.f
+incdir+rtl
rtl/wgne_pkg.sv
rtl/wgne_select.sv
rtl/weighted_grid_neighbour_expand_unit.sv
tb/tb_weighted_grid_neighbour_expand_unit.sv
